// File: design/mqd_pkg.sv
// Shared types and constants of the mipmap quad downsampler.
// No dependencies; the interfaces, the color lane and the top level use it.
`timescale 1ns / 1ps

package mqd_pkg;

	// Register indexes of the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_RED     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_GREEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_BLUE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_WEIGHT = 3'd5;

	// Channel mode codes; the unused code behaves as RGBA
	localparam logic [1:0] CH_GRAY = 2'd0;
	localparam logic [1:0] CH_RGB  = 2'd1;
	localparam logic [1:0] CH_RGBA = 2'd2;

	// Filter mode codes; the unused code behaves as plain box
	localparam logic [1:0] FILT_BOX  = 2'd0;
	localparam logic [1:0] FILT_AVG  = 2'd1;
	localparam logic [1:0] FILT_FILL = 2'd2;

	// Datapath widths
	localparam int unsigned TEXEL_W = 32;
	localparam int unsigned ASUM_W  = 10;  // sum of four alphas, up to 1020
	localparam int unsigned PROD_W  = 16;  // alpha times color byte
	localparam int unsigned ACC_W   = 18;  // weighted sum, up to 255 * 1020
	localparam int unsigned QUO_W   = 8;   // one quotient bit per divider stage
	localparam int unsigned AW_W    = 16;  // Q8.8 alpha weight
	localparam int unsigned SCALE_W = AW_W + ASUM_W;

	// Full alpha sum, the fixed divisor of fill mode
	localparam logic [ASUM_W-1:0] MAX_ALPHA_SUM = 10'd1020;
	localparam logic [7:0] BYTE_MAX = 8'd255;

	// Four bytes of one channel, one from each texel of the quad
	typedef logic [3:0][7:0] byte4_t;

endpackage

// File: design/mqd_if.sv
// Valid/ready channels of the mipmap quad downsampler: source quads in,
// reduced texels out. Depends on mqd_pkg for the texel width.
`timescale 1ns / 1ps

interface mqd_quad_if;
	logic valid;
	logic ready;
	logic [mqd_pkg::TEXEL_W-1:0] texel_top_left;
	logic [mqd_pkg::TEXEL_W-1:0] texel_top_right;
	logic [mqd_pkg::TEXEL_W-1:0] texel_bottom_left;
	logic [mqd_pkg::TEXEL_W-1:0] texel_bottom_right;

	modport source (
		output valid, texel_top_left, texel_top_right, texel_bottom_left,
		texel_bottom_right,
		input ready
	);
	modport sink (
		input valid, texel_top_left, texel_top_right, texel_bottom_left,
		texel_bottom_right,
		output ready
	);
endinterface

interface mqd_texel_if;
	logic valid;
	logic ready;
	logic [mqd_pkg::TEXEL_W-1:0] reduced_texel;

	modport source (output valid, reduced_texel, input ready);
	modport sink (input valid, reduced_texel, output ready);
endinterface

// File: design/mipmap_quad_downsample.sv
// Top level of the mipmap quad downsampler: configuration registers, box and
// alpha path, three color lanes and the output merge. Depends on mqd_pkg,
// mqd_if and mqd_lane.
`timescale 1ns / 1ps

// Takes one 2x2 quad of packed texels per cycle and returns one reduced texel
// per accepted quad; throughput is one quad per clock unless the output stalls.
// The pipeline has two stages of weighting, eight of division (the per-channel
// divider resolves one quotient bit per stage) and one output register. All
// stages advance together: while the output register holds an untaken result
// the whole pipeline and the input stall. Red, green and blue each have their
// own lane; the merge stage joins the lane quotients with the alpha result, or
// takes the box-filtered or fill texel when no division applies.
// Write the configuration registers only while no quad is in flight.
module mipmap_quad_downsample (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mqd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mqd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	mqd_quad_if.sink                          quad,
	mqd_texel_if.source                       texel
);

	localparam int unsigned DEPTH    = 2 + mqd_pkg::QUO_W;  // s1 .. s10
	localparam int unsigned LINE_LEN = mqd_pkg::QUO_W - 1;  // s4 .. s10

	typedef struct packed {
		logic [mqd_pkg::TEXEL_W-1:0] base;
		logic                        div_sel;
		logic [7:0]                  alpha;
	} side_t;

	// Configuration registers
	logic [1:0]                   chan_mode_q;
	logic [1:0]                   filt_mode_q;
	logic [7:0]                   fill_red_q;
	logic [7:0]                   fill_green_q;
	logic [7:0]                   fill_blue_q;
	logic [mqd_pkg::AW_W-1:0]     alpha_weight_q;

	logic                         adv;
	logic [DEPTH-1:0]             vld_q;
	logic                         out_valid_q;
	logic [mqd_pkg::TEXEL_W-1:0]  out_data_q;

	logic [mqd_pkg::TEXEL_W-1:0]  tx [4];
	mqd_pkg::byte4_t              plane [4];
	logic [mqd_pkg::ASUM_W-1:0]   asum_c;
	logic [7:0]                   amax_c;
	logic [7:0]                   box_c [4];
	logic                         rgba;
	logic                         weighted;
	logic                         use_fill;
	logic [mqd_pkg::TEXEL_W-1:0]  box_tex;
	logic [mqd_pkg::TEXEL_W-1:0]  base_c;

	logic [mqd_pkg::TEXEL_W-1:0]  base_s1;
	logic                         div_sel_s1;
	logic [mqd_pkg::ASUM_W-1:0]   asum_s1;
	logic [7:0]                   amax_s1;

	logic [mqd_pkg::TEXEL_W-1:0]  base_s2;
	logic                         div_sel_s2;
	logic [mqd_pkg::SCALE_W-1:0]  scaled_s2;
	logic [7:0]                   amax_s2;

	logic [mqd_pkg::SCALE_W-9:0]  scaled_hi;
	side_t                        side_s3;
	side_t                        side_line_q [LINE_LEN];
	side_t                        side_end;

	logic [7:0]                   fill_c [3];
	logic [mqd_pkg::QUO_W-1:0]    quo [3];

	// Take register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_mode_q    <= mqd_pkg::CH_RGBA;
			filt_mode_q    <= mqd_pkg::FILT_BOX;
			fill_red_q     <= '0;
			fill_green_q   <= '0;
			fill_blue_q    <= '0;
			alpha_weight_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				mqd_pkg::REG_CHANNEL_MODE: chan_mode_q    <= cfg_wdata[1:0];
				mqd_pkg::REG_FILTER_MODE:  filt_mode_q    <= cfg_wdata[1:0];
				mqd_pkg::REG_FILL_RED:     fill_red_q     <= cfg_wdata[7:0];
				mqd_pkg::REG_FILL_GREEN:   fill_green_q   <= cfg_wdata[7:0];
				mqd_pkg::REG_FILL_BLUE:    fill_blue_q    <= cfg_wdata[7:0];
				mqd_pkg::REG_ALPHA_WEIGHT: alpha_weight_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline whenever the output slot is free or taken
	assign adv        = !out_valid_q || texel.ready;
	assign quad.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[DEPTH-2:0], quad.valid};
			out_valid_q <= vld_q[DEPTH-1];
		end
	end

	// Split the quad into byte planes, one per channel
	always_comb begin
		tx[0] = quad.texel_top_left;
		tx[1] = quad.texel_top_right;
		tx[2] = quad.texel_bottom_left;
		tx[3] = quad.texel_bottom_right;
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 4; i++) begin
				plane[k][i] = tx[i][8*k +: 8];
			end
			box_c[k] = 8'((10'(plane[k][0]) + 10'(plane[k][1])
				+ 10'(plane[k][2]) + 10'(plane[k][3])) >> 2);
		end
	end

	// Alpha sum and largest alpha
	always_comb begin
		logic [7:0] max_a;
		logic [7:0] max_b;
		asum_c = 10'(plane[3][0]) + 10'(plane[3][1])
			+ 10'(plane[3][2]) + 10'(plane[3][3]);
		max_a  = (plane[3][0] > plane[3][1]) ? plane[3][0] : plane[3][1];
		max_b  = (plane[3][2] > plane[3][3]) ? plane[3][2] : plane[3][3];
		amax_c = (max_a > max_b) ? max_a : max_b;
	end

	// Decode modes and form the texel used when no division applies
	always_comb begin
		box_tex  = {box_c[3], box_c[2], box_c[1], box_c[0]};
		rgba     = 1'b0;
		base_c   = box_tex;
		case (chan_mode_q)
			mqd_pkg::CH_GRAY: base_c = {24'd0, box_c[0]};
			mqd_pkg::CH_RGB:  base_c = {8'd0, box_c[2], box_c[1], box_c[0]};
			default:          rgba   = 1'b1;
		endcase
		weighted = rgba && (filt_mode_q == mqd_pkg::FILT_AVG
			|| filt_mode_q == mqd_pkg::FILT_FILL);
		use_fill = filt_mode_q == mqd_pkg::FILT_FILL;
		// Fully transparent quad: plain average or fill color, alpha zero
		if (weighted && asum_c == '0) begin
			base_c = use_fill ? {8'd0, fill_blue_q, fill_green_q, fill_red_q}
				: {8'd0, box_c[2], box_c[1], box_c[0]};
		end
	end

	// Stage 1: side path registers
	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1    <= base_c;
			div_sel_s1 <= weighted && asum_c != '0;
			asum_s1    <= asum_c;
			amax_s1    <= amax_c;
		end
	end

	// Stage 2: scale the alpha sum by the Q8.8 weight
	always_ff @(posedge clk) begin
		if (adv) begin
			base_s2    <= base_s1;
			div_sel_s2 <= div_sel_s1;
			scaled_s2  <= mqd_pkg::SCALE_W'(alpha_weight_q) * mqd_pkg::SCALE_W'(asum_s1);
			amax_s2    <= amax_s1;
		end
	end

	// Stage 3: limit the new alpha by the largest source alpha
	assign scaled_hi = scaled_s2[mqd_pkg::SCALE_W-1:8];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.base    <= base_s2;
			side_s3.div_sel <= div_sel_s2;
			side_s3.alpha   <= (scaled_hi < (mqd_pkg::SCALE_W-8)'(amax_s2))
				? scaled_hi[7:0] : amax_s2;
		end
	end

	// Delay the side result to meet the lane quotients
	always_ff @(posedge clk) begin
		if (adv) begin
			side_line_q[0] <= side_s3;
			for (int i = 1; i < LINE_LEN; i++) begin
				side_line_q[i] <= side_line_q[i-1];
			end
		end
	end

	assign side_end = side_line_q[LINE_LEN-1];

	// Color lanes: red, green, blue
	assign fill_c[0] = fill_red_q;
	assign fill_c[1] = fill_green_q;
	assign fill_c[2] = fill_blue_q;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		mqd_lane u_lane (
			.clk      (clk),
			.en       (adv),
			.color    (plane[k]),
			.alpha    (plane[3]),
			.asum     (asum_c),
			.fill     (fill_c[k]),
			.use_fill (use_fill),
			.quotient (quo[k])
		);
	end

	// Merge lanes and side path into the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= side_end.div_sel
				? {side_end.alpha, quo[2], quo[1], quo[0]} : side_end.base;
		end
	end

	assign texel.valid         = out_valid_q;
	assign texel.reduced_texel = out_data_q;

	// A stalled pipeline keeps its occupancy
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline occupancy changed during a stall");

	// An accepted request occupies the first stage next cycle
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(quad.valid && quad.ready) |=> vld_q[0])
		else $error("accepted request did not enter the pipeline");

	// Gray output leaves the upper bytes clear
	a_gray_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(texel.valid && chan_mode_q == mqd_pkg::CH_GRAY)
		|-> texel.reduced_texel[31:8] == '0)
		else $error("gray result carries data in unused bytes");

	// RGB output leaves the alpha byte clear
	a_rgb_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(texel.valid && chan_mode_q == mqd_pkg::CH_RGB)
		|-> texel.reduced_texel[31:24] == '0)
		else $error("RGB result carries data in the alpha byte");

endmodule

// File: design/mqd_lane.sv
// One color lane: alpha-weighted sum of a channel over the quad, then a
// pipelined restoring divider, one quotient bit per stage.
// Depends on mqd_pkg.
`timescale 1ns / 1ps

module mqd_lane (
	input  logic                         clk,
	input  logic                         en,
	input  mqd_pkg::byte4_t              color,
	input  mqd_pkg::byte4_t              alpha,
	input  logic [mqd_pkg::ASUM_W-1:0]   asum,
	input  logic [7:0]                   fill,
	input  logic                         use_fill,
	output logic [mqd_pkg::QUO_W-1:0]    quotient
);

	localparam int unsigned NSTAGE = mqd_pkg::QUO_W;

	logic [mqd_pkg::PROD_W-1:0] prod_s1 [4];
	logic [mqd_pkg::ASUM_W-1:0] asum_s1;
	logic [7:0]                 fill_s1;
	logic                       use_fill_s1;

	logic [mqd_pkg::ACC_W-1:0]  acc_s2;
	logic [mqd_pkg::ASUM_W-1:0] dvs_s2;

	logic [mqd_pkg::ACC_W-1:0]  rem_q [NSTAGE];
	logic [mqd_pkg::ASUM_W-1:0] dvs_q [NSTAGE];
	logic [mqd_pkg::QUO_W-1:0]  quo_q [NSTAGE];

	logic [mqd_pkg::ACC_W-1:0] prod_sum;
	logic [mqd_pkg::ACC_W-1:0] fill_term;

	// Stage 1: weight each color byte by its alpha
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= mqd_pkg::PROD_W'(alpha[i]) * mqd_pkg::PROD_W'(color[i]);
			end
			asum_s1     <= asum;
			fill_s1     <= fill;
			use_fill_s1 <= use_fill;
		end
	end

	// Stage 2: add up the products, blend in the fill color, pick the divisor
	always_comb begin
		prod_sum = mqd_pkg::ACC_W'(prod_s1[0]) + mqd_pkg::ACC_W'(prod_s1[1])
			+ mqd_pkg::ACC_W'(prod_s1[2]) + mqd_pkg::ACC_W'(prod_s1[3]);
		fill_term = mqd_pkg::ACC_W'(mqd_pkg::MAX_ALPHA_SUM - asum_s1)
			* mqd_pkg::ACC_W'(fill_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= use_fill_s1 ? prod_sum + fill_term : prod_sum;
			dvs_s2 <= use_fill_s1 ? mqd_pkg::MAX_ALPHA_SUM : asum_s1;
		end
	end

	// Divider stages: the quotient never exceeds one byte, so the stage for
	// bit b compares against the divisor shifted left by b
	for (genvar j = 0; j < NSTAGE; j++) begin : g_div
		localparam int unsigned SHIFT = NSTAGE - 1 - j;

		logic [mqd_pkg::ACC_W-1:0]  rem_in;
		logic [mqd_pkg::ASUM_W-1:0] dvs_in;
		logic [mqd_pkg::QUO_W-1:0]  quo_in;
		logic [mqd_pkg::ACC_W-1:0]  trial;
		logic                       take;

		if (j == 0) begin : g_first
			assign rem_in = acc_s2;
			assign dvs_in = dvs_s2;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign dvs_in = dvs_q[j-1];
			assign quo_in = quo_q[j-1];
		end

		assign trial = mqd_pkg::ACC_W'(dvs_in) << SHIFT;
		assign take  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= take ? rem_in - trial : rem_in;
				dvs_q[j] <= dvs_in;
				quo_q[j] <= quo_in | (mqd_pkg::QUO_W'(take) << SHIFT);
			end
		end
	end

	assign quotient = quo_q[NSTAGE-1];

endmodule
